// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of the table interpolator.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle property failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle property failed");

`endif

// ----- design/bti_pkg.sv -----
// Shared types and constants of the bilinear table interpolator.
// No dependencies; every design module except bti_ram imports it.
package bti_pkg;

  localparam int DataWidth         = 32;
  localparam int PointsWidth       = 5;
  localparam int FieldWidth        = 4;
  localparam int FracWidth         = 16;
  localparam int RegAddrWidth      = 5;

  localparam int MaxRowsDefault    = 16;
  localparam int MaxColsDefault    = 16;
  localparam int ComponentsDefault = 9;
  localparam int ValueWidthDefault = 32;

  localparam logic ModeWrite = 1'b0;
  localparam logic ModeQuery = 1'b1;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] RegAxis0Min     = 3'd0;
  localparam logic [2:0] RegAxis0Max     = 3'd1;
  localparam logic [2:0] RegAxis0Points  = 3'd2;
  localparam logic [2:0] RegAxis0InvStep = 3'd3;
  localparam logic [2:0] RegAxis1Min     = 3'd4;
  localparam logic [2:0] RegAxis1Max     = 3'd5;
  localparam logic [2:0] RegAxis1Points  = 3'd6;
  localparam logic [2:0] RegAxis1InvStep = 3'd7;

  typedef struct packed {
    logic                          mode;
    logic [FieldWidth-1:0]         row;
    logic [FieldWidth-1:0]         col;
    logic [FieldWidth-1:0]         slot;
    logic signed [DataWidth-1:0]   word;
    logic signed [DataWidth-1:0]   coord0;
    logic signed [DataWidth-1:0]   coord1;
  } item_t;

  typedef struct packed {
    logic [FieldWidth-1:0]         component;
    logic signed [DataWidth-1:0]   result_value;
    logic                          clamped;
    logic                          last;
  } result_t;

  typedef struct packed {
    logic signed [DataWidth-1:0]   min_val;
    logic signed [DataWidth-1:0]   max_val;
    logic [PointsWidth-1:0]        points;
    logic [DataWidth-1:0]          inv_step;
  } axis_cfg_t;

  typedef struct packed {
    logic done;
    logic do10;
    logic do01;
    logic clamped;
  } loc_status_t;

  typedef struct packed {
    logic [FracWidth-1:0]  u;
    logic [FracWidth-1:0]  v;
    logic                  do10;
    logic                  do01;
    logic [FieldWidth-1:0] comp;
    logic                  last;
    logic                  clamped;
  } blend_tag_t;

endpackage

// ----- design/bti_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/bti_locate.sv -----
// Query setup unit: clamps both coordinates, then finds grid index and fraction
// per axis with one shared 32x32 multiplier. Depends on bti_pkg.
module bti_locate #(
  parameter int MAX_ROWS = bti_pkg::MaxRowsDefault,
  parameter int MAX_COLS = bti_pkg::MaxColsDefault,
  localparam int IW0 = $clog2(MAX_ROWS),
  localparam int IW1 = $clog2(MAX_COLS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          go_i,
  input  logic signed [31:0]            coord0_i,
  input  logic signed [31:0]            coord1_i,
  input  bti_pkg::axis_cfg_t            cfg0_i,
  input  bti_pkg::axis_cfg_t            cfg1_i,
  output logic [IW0-1:0]                i0_o,
  output logic [IW1-1:0]                j0_o,
  output logic [bti_pkg::FracWidth-1:0] u_o,
  output logic [bti_pkg::FracWidth-1:0] v_o,
  output bti_pkg::loc_status_t          status_o
);
  import bti_pkg::*;

  localparam logic [2:0] LIdle = 3'd0;
  localparam logic [2:0] LPrep = 3'd1;
  localparam logic [2:0] LMul0 = 3'd2;
  localparam logic [2:0] LMul1 = 3'd3;
  localparam logic [2:0] LRes1 = 3'd4;

  // Highest usable index of an axis; zero and oversize point counts are folded in.
  function automatic int eff_last(input logic [PointsWidth-1:0] pts, input int limit);
    int n;
    n = int'(pts);
    if (n == 0) n = 1;
    if (n > limit) n = limit;
    return n - 1;
  endfunction

  // Returns {clamp flag, nonnegative offset from the axis minimum}.
  function automatic logic [32:0] axis_dist(input logic signed [31:0] c,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
    logic signed [31:0] s;
    logic signed [32:0] diff;
    logic               flag;
    s    = c;
    flag = 1'b0;
    if (s < lo) begin
      s    = lo;
      flag = 1'b1;
    end
    if (s > hi) begin
      s    = hi;
      flag = 1'b1;
    end
    diff = $signed({s[31], s}) - $signed({lo[31], lo});
    return {flag, (diff[32] || diff == '0) ? 32'd0 : diff[31:0]};
  endfunction

  logic [2:0]         step_q, step_d;
  logic signed [31:0] coord0_q, coord1_q;
  logic [31:0]        dist0_q, dist1_q;
  logic [IW0-1:0]     last0_q;
  logic [IW1-1:0]     last1_q;
  logic               clamped_q;
  logic [63:0]        prod_q;
  logic [IW0-1:0]     i0_q;
  logic [IW1-1:0]     j0_q;
  logic [15:0]        u_q, v_q;

  logic [IW0-1:0]     last0_c;
  logic [IW1-1:0]     last1_c;
  logic [32:0]        dist0_c, dist1_c;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;

  assign last0_c = IW0'(eff_last(cfg0_i.points, MAX_ROWS));
  assign last1_c = IW1'(eff_last(cfg1_i.points, MAX_COLS));
  assign dist0_c = axis_dist(coord0_q, cfg0_i.min_val, cfg0_i.max_val);
  assign dist1_c = axis_dist(coord1_q, cfg1_i.min_val, cfg1_i.max_val);

  assign mul_a = (step_q == LMul0) ? dist0_q : dist1_q;
  assign mul_b = (step_q == LMul0) ? cfg0_i.inv_step : cfg1_i.inv_step;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    step_d = step_q;
    unique case (step_q)
      LIdle:   if (go_i) step_d = LPrep;
      LPrep:   step_d = LMul0;
      LMul0:   step_d = LMul1;
      LMul1:   step_d = LRes1;
      LRes1:   step_d = LIdle;
      default: step_d = LIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= LIdle;
    end else begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_q == LIdle && go_i) begin
      coord0_q <= coord0_i;
      coord1_q <= coord1_i;
    end
    if (step_q == LPrep) begin
      // A one-point axis sits at index zero and never reports clamping.
      dist0_q   <= (last0_c == '0) ? 32'd0 : dist0_c[31:0];
      dist1_q   <= (last1_c == '0) ? 32'd0 : dist1_c[31:0];
      last0_q   <= last0_c;
      last1_q   <= last1_c;
      clamped_q <= (last0_c != '0 && dist0_c[32]) || (last1_c != '0 && dist1_c[32]);
    end
    if (step_q == LMul0 || step_q == LMul1) begin
      prod_q <= mul_p;
    end
    if (step_q == LMul1) begin
      if (prod_q[63:32] > 32'(last0_q)) begin
        i0_q <= last0_q;
        u_q  <= '0;
      end else begin
        i0_q <= prod_q[32 +: IW0];
        u_q  <= prod_q[31:16];
      end
    end
    if (step_q == LRes1) begin
      if (prod_q[63:32] > 32'(last1_q)) begin
        j0_q <= last1_q;
        v_q  <= '0;
      end else begin
        j0_q <= prod_q[32 +: IW1];
        v_q  <= prod_q[31:16];
      end
    end
  end

  assign i0_o             = i0_q;
  assign j0_o             = j0_q;
  assign u_o              = u_q;
  assign v_o              = v_q;
  assign status_o.done    = (step_q == LRes1);
  assign status_o.do10    = (i0_q < last0_q);
  assign status_o.do01    = (j0_q < last1_q);
  assign status_o.clamped = clamped_q;

endmodule

// ----- design/bti_table.sv -----
// Grid table in four RAM banks split by row and column parity, so the four
// corners of a cell come out in one read. Depends on bti_pkg and bti_ram.
module bti_table #(
  parameter int MAX_ROWS   = bti_pkg::MaxRowsDefault,
  parameter int MAX_COLS   = bti_pkg::MaxColsDefault,
  parameter int COMPONENTS = bti_pkg::ComponentsDefault,
  localparam int IW0 = $clog2(MAX_ROWS),
  localparam int IW1 = $clog2(MAX_COLS)
) (
  input  logic                           clk_i,
  input  logic                           wr_en_i,
  input  logic [bti_pkg::FieldWidth-1:0] wr_row_i,
  input  logic [bti_pkg::FieldWidth-1:0] wr_col_i,
  input  logic [bti_pkg::FieldWidth-1:0] wr_slot_i,
  input  logic [bti_pkg::DataWidth-1:0]  wr_data_i,
  input  logic                           rd_en_i,
  input  logic [IW0-1:0]                 rd_i0_i,
  input  logic [IW1-1:0]                 rd_j0_i,
  input  logic [bti_pkg::FieldWidth-1:0] rd_comp_i,
  output logic signed [31:0]             c00_o,
  output logic signed [31:0]             c10_o,
  output logic signed [31:0]             c01_o,
  output logic signed [31:0]             c11_o
);
  import bti_pkg::*;

  // One spare half-row and half-column so the corner past the edge has an address.
  localparam int HalfRows = MAX_ROWS / 2 + 1;
  localparam int HalfCols = MAX_COLS / 2 + 1;
  localparam int Depth    = HalfRows * HalfCols * COMPONENTS;
  localparam int AW       = (Depth > 1) ? $clog2(Depth) : 1;

  logic          wr_ok;
  logic [1:0]    wr_bank;
  logic [AW-1:0] wr_addr;
  logic [1:0]    par_q;
  logic [DataWidth-1:0] bank_rdata [4];

  assign wr_ok   = (int'(wr_row_i) < MAX_ROWS) && (int'(wr_col_i) < MAX_COLS)
                && (int'(wr_slot_i) < COMPONENTS);
  assign wr_bank = {wr_row_i[0], wr_col_i[0]};
  assign wr_addr = AW'((int'(wr_row_i >> 1) * HalfCols + int'(wr_col_i >> 1)) * COMPONENTS
                       + int'(wr_slot_i));

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam bit RowPar = (b / 2) == 1;
    localparam bit ColPar = (b % 2) == 1;
    int            half_row, half_col;
    logic [AW-1:0] rd_addr;

    // Take the base index if its parity matches this bank, else the next one.
    always_comb begin
      half_row = (int'(rd_i0_i) + ((rd_i0_i[0] != RowPar) ? 1 : 0)) >> 1;
      half_col = (int'(rd_j0_i) + ((rd_j0_i[0] != ColPar) ? 1 : 0)) >> 1;
      rd_addr  = AW'((half_row * HalfCols + half_col) * COMPONENTS + int'(rd_comp_i));
    end

    bti_ram #(
      .WIDTH(DataWidth),
      .DEPTH(Depth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en_i && wr_ok && wr_bank == 2'(b)),
      .waddr_i(wr_addr),
      .wdata_i(wr_data_i),
      .re_i   (rd_en_i),
      .raddr_i(rd_addr),
      .rdata_o(bank_rdata[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      par_q <= {rd_i0_i[0], rd_j0_i[0]};
    end
  end

  assign c00_o = bank_rdata[{par_q[1], par_q[0]}];
  assign c10_o = bank_rdata[{~par_q[1], par_q[0]}];
  assign c01_o = bank_rdata[{par_q[1], ~par_q[0]}];
  assign c11_o = bank_rdata[{~par_q[1], ~par_q[0]}];

endmodule

// ----- design/bti_blend.sv -----
// Blend pipeline: weights the four corners along the first axis, then along
// the second, rounds and saturates. Depends on bti_pkg.
module bti_blend #(
  parameter int VALUE_WIDTH = bti_pkg::ValueWidthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  bti_pkg::blend_tag_t tag_i,
  input  logic signed [31:0]  c00_i,
  input  logic signed [31:0]  c10_i,
  input  logic signed [31:0]  c01_i,
  input  logic signed [31:0]  c11_i,
  output logic                result_valid_o,
  output bti_pkg::result_t    result_o
);
  import bti_pkg::*;

  localparam logic signed [67:0] RoundBias = 68'sh8000_0000;
  localparam logic signed [49:0] SatMax    = (50'sd1 <<< (VALUE_WIDTH - 1)) - 50'sd1;
  localparam logic signed [49:0] SatMin    = -SatMax - 50'sd1;

  logic signed [17:0] wa, wu, wb, wv;
  logic signed [31:0] c10m, c01m, c11m;
  logic signed [49:0] t0_d, t1_d, t0_q, t1_q;
  logic signed [67:0] acc_d, acc_q;
  logic signed [49:0] val, sat;
  blend_tag_t         tag_a_q, tag_b_q;
  logic               valid_a_q, valid_b_q, valid_q;
  result_t            result_q;

  // Stage A: interpolate along the first axis for both columns.
  always_comb begin
    wa   = $signed({1'b0, 17'h10000 - {1'b0, tag_i.u}});
    wu   = $signed({2'b00, tag_i.u});
    c10m = tag_i.do10 ? c10_i : '0;
    c01m = tag_i.do01 ? c01_i : '0;
    c11m = (tag_i.do10 && tag_i.do01) ? c11_i : '0;
    t0_d = wa * c00_i + wu * c10m;
    t1_d = wa * c01m + wu * c11m;
  end

  // Stage B: interpolate along the second axis and add the rounding bias.
  always_comb begin
    wb    = $signed({1'b0, 17'h10000 - {1'b0, tag_a_q.v}});
    wv    = $signed({2'b00, tag_a_q.v});
    acc_d = wb * t0_q + wv * t1_q + RoundBias;
  end

  always_comb begin
    val = {{14{acc_q[67]}}, acc_q[67:32]};
    if (val > SatMax) begin
      sat = SatMax;
    end else if (val < SatMin) begin
      sat = SatMin;
    end else begin
      sat = val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_q   <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    tag_a_q <= tag_i;
    acc_q   <= acc_d;
    tag_b_q <= tag_a_q;
    result_q.component    <= tag_b_q.comp;
    result_q.result_value <= sat[31:0];
    result_q.clamped      <= tag_b_q.clamped;
    result_q.last         <= tag_b_q.last;
  end

  assign result_valid_o = valid_q;
  assign result_o       = result_q;

endmodule

// ----- design/bilinear_table_interp.sv -----
// Bilinear interpolation over a two-axis grid table of component vectors.
// Depends on bti_pkg, bti_locate, bti_table, bti_blend and bti_ram.
//
// Usage: an item is taken when start is high and busy is low. A write item
// (mode 0) stores one table word at the accepting edge and leaves busy low.
// A query item (mode 1) raises busy through setup, where one 32x32 multiplier
// serves both axes in turn, then through one component per cycle for the 9
// components read from four parity-banked table RAMs. Its results come back
// as 9 consecutive beats on result_o, marked by result_valid_o once the
// table read and the blend stages are through, with last on the final beat.
// A new query is taken once busy falls; the blend pipeline drains while the
// next one starts. The receiver cannot stall, so each beat is shown for
// exactly one cycle. Configuration goes through the APB port, one register
// per 32-bit word; the user must write it only while no query is in flight,
// which the block itself does not enforce. Reset clears the control state
// and sets the axis registers to min = max = step = 0 and one point per
// axis. The table holds no defined data after reset and needs no clearing
// pass; every entry a query touches must have been written first.
module bilinear_table_interp #(
  parameter int MAX_ROWS    = bti_pkg::MaxRowsDefault,
  parameter int MAX_COLS    = bti_pkg::MaxColsDefault,
  parameter int COMPONENTS  = bti_pkg::ComponentsDefault,
  parameter int VALUE_WIDTH = bti_pkg::ValueWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bti_pkg::RegAddrWidth-1:0] paddr,
  input  logic [bti_pkg::DataWidth-1:0]    pwdata,
  output logic [bti_pkg::DataWidth-1:0]    prdata,
  output logic                             pready,
  input  logic                             start,
  output logic                             busy,
  input  bti_pkg::item_t                   item_i,
  output logic                             result_valid_o,
  output bti_pkg::result_t                 result_o
);
  import bti_pkg::*;

  localparam int IW0 = $clog2(MAX_ROWS);
  localparam int IW1 = $clog2(MAX_COLS);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;

  axis_cfg_t             cfg0_q, cfg1_q;
  logic [1:0]            state_q, state_d;
  logic [FieldWidth-1:0] comp_q;
  logic                  accept, cfg_wr, issue, last_comp;
  logic [2:0]            reg_sel;
  logic [IW0-1:0]        i0;
  logic [IW1-1:0]        j0;
  logic [FracWidth-1:0]  u, v;
  loc_status_t           loc_status;
  blend_tag_t            tag_q;
  logic                  rd_valid_q;
  logic signed [31:0]    c00, c10, c01, c11;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg0_q <= '{min_val: '0, max_val: '0, points: PointsWidth'(1), inv_step: '0};
      cfg1_q <= '{min_val: '0, max_val: '0, points: PointsWidth'(1), inv_step: '0};
    end else if (cfg_wr) begin
      unique case (reg_sel)
        RegAxis0Min:     cfg0_q.min_val  <= pwdata;
        RegAxis0Max:     cfg0_q.max_val  <= pwdata;
        RegAxis0Points:  cfg0_q.points   <= pwdata[PointsWidth-1:0];
        RegAxis0InvStep: cfg0_q.inv_step <= pwdata;
        RegAxis1Min:     cfg1_q.min_val  <= pwdata;
        RegAxis1Max:     cfg1_q.max_val  <= pwdata;
        RegAxis1Points:  cfg1_q.points   <= pwdata[PointsWidth-1:0];
        RegAxis1InvStep: cfg1_q.inv_step <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegAxis0Min:     prdata = cfg0_q.min_val;
      RegAxis0Max:     prdata = cfg0_q.max_val;
      RegAxis0Points:  prdata = DataWidth'(cfg0_q.points);
      RegAxis0InvStep: prdata = cfg0_q.inv_step;
      RegAxis1Min:     prdata = cfg1_q.min_val;
      RegAxis1Max:     prdata = cfg1_q.max_val;
      RegAxis1Points:  prdata = DataWidth'(cfg1_q.points);
      RegAxis1InvStep: prdata = cfg1_q.inv_step;
      default:         prdata = '0;
    endcase
  end

  assign busy      = (state_q != StIdle);
  assign accept    = start && !busy;
  assign issue     = (state_q == StRun);
  assign last_comp = (comp_q == FieldWidth'(COMPONENTS - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept && item_i.mode == ModeQuery) state_d = StSetup;
      StSetup: if (loc_status.done) state_d = StRun;
      StRun:   if (last_comp) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      comp_q     <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= issue;
      if (issue) begin
        comp_q <= last_comp ? '0 : comp_q + FieldWidth'(1);
      end
    end
  end

  // Sideband is registered alongside the RAM read so it lines up with the corners.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      tag_q.u       <= u;
      tag_q.v       <= v;
      tag_q.do10    <= loc_status.do10;
      tag_q.do01    <= loc_status.do01;
      tag_q.comp    <= comp_q;
      tag_q.last    <= last_comp;
      tag_q.clamped <= loc_status.clamped;
    end
  end

  bti_locate #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_locate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (accept && item_i.mode == ModeQuery),
    .coord0_i(item_i.coord0),
    .coord1_i(item_i.coord1),
    .cfg0_i  (cfg0_q),
    .cfg1_i  (cfg1_q),
    .i0_o    (i0),
    .j0_o    (j0),
    .u_o     (u),
    .v_o     (v),
    .status_o(loc_status)
  );

  bti_table #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .COMPONENTS(COMPONENTS)
  ) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (accept && item_i.mode == ModeWrite),
    .wr_row_i (item_i.row),
    .wr_col_i (item_i.col),
    .wr_slot_i(item_i.slot),
    .wr_data_i(item_i.word),
    .rd_en_i  (issue),
    .rd_i0_i  (i0),
    .rd_j0_i  (j0),
    .rd_comp_i(comp_q),
    .c00_o    (c00),
    .c10_o    (c10),
    .c01_o    (c01),
    .c11_o    (c11)
  );

  bti_blend #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_blend (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (rd_valid_q),
    .tag_i         (tag_q),
    .c00_i         (c00),
    .c10_i         (c10),
    .c01_i         (c01),
    .c11_i         (c11),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

endmodule

// ----- design/bti_checker.sv -----
// Port-level checker for the table interpolator, bound to the top level.
// Depends on bti_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bti_checker #(
  parameter int COMPONENTS = bti_pkg::ComponentsDefault
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_i,
  input bti_pkg::item_t   item_i,
  input logic             res_valid_i,
  input bti_pkg::result_t res_i
);
  import bti_pkg::*;

  // A query holds the block busy; a table write does not.
  `ASSERT_NEXT(a_query_sets_busy, start_i && !busy_i && item_i.mode == ModeQuery, busy_i)
  `ASSERT_NEXT(a_write_stays_idle, start_i && !busy_i && item_i.mode == ModeWrite, !busy_i)
  // Beats of one query come back to back, in component order, with one clamp flag.
  `ASSERT_NEXT(a_beats_in_order, res_valid_i && !res_i.last, res_valid_i && res_i.component == $past(res_i.component) + 4'd1 && res_i.clamped == $past(res_i.clamped))
  `ASSERT_NOW(a_last_on_final, res_valid_i, res_i.last == (res_i.component == 4'(COMPONENTS - 1)))

endmodule

bind bilinear_table_interp bti_checker #(
  .COMPONENTS(COMPONENTS)
) u_bti_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start),
  .busy_i     (busy),
  .item_i     (item_i),
  .res_valid_i(result_valid_o),
  .res_i      (result_o)
);
